// ----- design/obsi_pkg.sv -----
package obsi_pkg;

	localparam int CAPACITY  = 32;
	localparam int CNT_W     = $clog2(CAPACITY + 1);
	localparam int IDX_W     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int VAL_W     = 32;
	localparam int OUT_CNT_W = 6;

	typedef enum logic [1:0] {
		FUNC_ADD      = 2'd0,
		FUNC_REMOVE   = 2'd1,
		FUNC_CONTAINS = 2'd2,
		FUNC_CLEAR    = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_UPDATE
	} state_t;

	// commands from the controller to the datapath
	typedef struct packed {
		logic load;
		logic search;
		logic update;
	} cmd_t;

endpackage

// ----- design/obsi_ctrl.sv -----
module obsi_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	output obsi_pkg::cmd_t   cmd
);
	import obsi_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		cmd.load   = 1'b0;
		cmd.search = 1'b0;
		cmd.update = 1'b0;
		busy       = 1'b1;
		case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.load = 1'b1;
					state_d  = ST_SEARCH;
				end
			end
			ST_SEARCH: begin
				cmd.search = 1'b1;
				state_d    = ST_UPDATE;
			end
			ST_UPDATE: begin
				cmd.update = 1'b1;
				state_d    = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// ----- design/obsi_dp.sv -----
module obsi_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  obsi_pkg::cmd_t                cmd,
	input  logic [1:0]                    func,
	input  logic signed [31:0]            value,
	output logic                          done,
	output logic                          ok,
	output logic [obsi_pkg::OUT_CNT_W-1:0] count
);
	import obsi_pkg::*;

	logic [VAL_W-1:0]    cell_q [CAPACITY];
	logic [CNT_W-1:0]    count_q;
	func_t               func_q;
	logic [VAL_W-1:0]    value_q;
	logic [CAPACITY-1:0] match_s1;
	logic                ok_q;
	logic                done_q;

	logic                found;
	logic [IDX_W-1:0]    pos;
	logic                room;
	logic                do_add;
	logic                do_remove;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q  <= func_t'(func);
			value_q <= value;
		end
	end

	// every cell compares against the request value at once
	always_ff @(posedge clk) begin
		if (cmd.search) begin
			for (int i = 0; i < CAPACITY; i++) begin
				match_s1[i] <= (cell_q[i] == value_q) && (CNT_W'(i) < count_q);
			end
		end
	end

	// members are distinct, so at most one match: encode it by or-ing indices
	always_comb begin
		pos = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (match_s1[i]) begin
				pos = pos | IDX_W'(i);
			end
		end
	end

	assign found     = |match_s1;
	assign room      = count_q < CNT_W'(CAPACITY);
	assign do_add    = cmd.update && (func_q == FUNC_ADD) && !found && room;
	assign do_remove = cmd.update && (func_q == FUNC_REMOVE) && found;

	always_ff @(posedge clk) begin
		for (int i = 0; i < CAPACITY; i++) begin
			if (do_add && (CNT_W'(i) == count_q)) begin
				cell_q[i] <= value_q;
			end else if (do_remove && (IDX_W'(i) >= pos) && (i + 1 < CAPACITY)) begin
				// shift from the upper neighbour to close the gap
				cell_q[i] <= cell_q[(i + 1 < CAPACITY) ? i + 1 : i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= cmd.update;
			if (cmd.update) begin
				case (func_q)
					FUNC_ADD: begin
						if (do_add) begin
							count_q <= count_q + CNT_W'(1);
						end
					end
					FUNC_REMOVE: begin
						if (do_remove) begin
							count_q <= count_q - CNT_W'(1);
						end
					end
					FUNC_CLEAR: begin
						count_q <= '0;
					end
					default: begin
						count_q <= count_q;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.update) begin
			case (func_q)
				FUNC_ADD:      ok_q <= !found && room;
				FUNC_REMOVE:   ok_q <= found;
				FUNC_CONTAINS: ok_q <= found;
				default:       ok_q <= 1'b1;
			endcase
		end
	end

	assign done  = done_q;
	assign ok    = ok_q;
	assign count = OUT_CNT_W'(count_q);

endmodule

// ----- design/ordered_bounded_int_set.sv -----
// Set of up to 32 distinct signed 32-bit integers, held in insertion order.
// A request (func, value) is latched at the edge where start is high and busy
// is low; busy then stays high through a search state, in which every stored
// entry compares with the value at once, and an update state, in which the
// entries are written or shifted down and the count updated. In the cycle
// after that, done is high for exactly one cycle with ok and count, and a new
// request can be taken in that same cycle.
// The receiver cannot hold a result off: ok and count are valid only while
// done is high. count is the member count after the request.
module ordered_bounded_int_set (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         func,
	input  logic signed [31:0] value,
	output logic               done,
	output logic               ok,
	output logic [5:0]         count
);
	import obsi_pkg::*;

	cmd_t cmd;

	obsi_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd)
	);

	obsi_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.func   (func),
		.value  (value),
		.done   (done),
		.ok     (ok),
		.count  (count)
	);

	// a result is strobed for one cycle only
	assert property (@(posedge clk) disable iff (!arst_n) done |=> !done)
		else $error("done high on two consecutive cycles");

	// an accepted request keeps the block busy until its result
	assert property (@(posedge clk) disable iff (!arst_n) (start && !busy) |=> busy)
		else $error("request accepted but block not busy");

	assert property (@(posedge clk) disable iff (!arst_n) (start && !busy) |=> ##1 !done)
		else $error("result strobed too early");

	// the result appears once the block is free again
	assert property (@(posedge clk) disable iff (!arst_n) done |-> !busy)
		else $error("result strobed while busy");

endmodule
